### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
// each one samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold whenever ante holds
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### hw/rtl/tib_pkg.sv
// ----------------------------------------------------------------------------
// tib_pkg
// Types and constants shared by the invalidate batcher front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package tib_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned Log2W = 6;

  // transaction kinds on the input channel
  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] BAR_SYSTEM = 2'd2;

  localparam logic CMD_RANGE = 1'b0;
  localparam logic CMD_ALL   = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_RANGE_OK    = 3'd0;
  localparam logic [2:0] CFG_RANGED_MODE = 3'd1;
  localparam logic [2:0] CFG_RANGE_LIMIT = 3'd2;
  localparam logic [2:0] CFG_PAGE_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_DIR_BASE    = 3'd4;

  localparam logic [16:0] RANGE_TOTAL_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_ADD,
    OP_END
  } tib_op_e;

  typedef struct packed {
    tib_op_e          op;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] length;
    logic [Log2W-1:0] lo;
    logic [Log2W-1:0] hi;
    logic [1:0]       barrier;
  } tib_item_t;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] length;
    logic [Log2W-1:0] lo;
    logic [Log2W-1:0] hi;
  } tib_entry_t;

  typedef struct packed {
    logic             range_ok;
    logic             ranged_mode;
    logic [15:0]      range_limit;
    logic [31:0]      page_limit;
    logic [AddrW-1:0] dir_base;
  } tib_cfg_t;

  typedef struct packed {
    logic             command;
    logic [AddrW-1:0] base_address;
    logic [Log2W-1:0] depth_log2;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] length;
    logic [Log2W-1:0] step_log2;
    logic [1:0]       barrier;
    logic             last;
  } tib_cmd_t;

  typedef struct packed {
    logic flushing;
    logic pop;
  } tib_status_t;

endpackage

`default_nettype wire

### hw/rtl/tlb_invalidate_batcher.sv
// ----------------------------------------------------------------------------
// tlb_invalidate_batcher
// Batches TLB invalidation requests and flushes them as invalidate commands.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                  contents
//   in       sink       in_valid_i / in_ready_o    kind, range, size mask, barrier
//   out      source     out_valid_o / out_ready_i  one invalidate command
//   cfg      sink       cfg_we_i                   register index and data
//
// the back end applies begin and add transactions from the queue; a two-entry
// queue lets the input keep accepting while the back end or output stalls.
// a flush of n stored entries emits one command per cycle from the entry ram
// while the output accepts them; an invalidate-all flush emits a single command.
// the back end accepts nothing from the queue while a flush runs.
// reset clears batch counters and sets config defaults; entry ram is not cleared.
`default_nettype none

`include "assert_macros.svh"

module tlb_invalidate_batcher #(
  parameter int unsigned MaxEntries = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_wdata_i,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [63:0] range_start_i,
  input  wire logic [63:0] range_length_i,
  input  wire logic [63:0] size_mask_i,
  input  wire logic [1:0]  barrier_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             command_o,
  output logic [63:0]      base_address_o,
  output logic [5:0]       depth_size_log2_o,
  output logic [63:0]      out_start_o,
  output logic [63:0]      out_length_o,
  output logic [5:0]       step_size_log2_o,
  output logic [1:0]       out_barrier_o,
  output logic             last_o
);

  tib_pkg::tib_cfg_t    cfg_q, cfg_d;
  tib_pkg::tib_item_t   fr_item;
  logic                 fr_keep;
  logic                 q_ready;
  logic                 q_push;
  logic                 q_valid;
  tib_pkg::tib_item_t   q_item;
  tib_pkg::tib_cmd_t    out_cmd;
  tib_pkg::tib_status_t bk_st;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tib_pkg::CFG_RANGE_OK:    cfg_d.range_ok    = cfg_wdata_i[0];
        tib_pkg::CFG_RANGED_MODE: cfg_d.ranged_mode = cfg_wdata_i[0];
        tib_pkg::CFG_RANGE_LIMIT: cfg_d.range_limit = cfg_wdata_i[15:0];
        tib_pkg::CFG_PAGE_LIMIT:  cfg_d.page_limit  = cfg_wdata_i[31:0];
        tib_pkg::CFG_DIR_BASE:    cfg_d.dir_base    = cfg_wdata_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_ok    <= 1'b1;
      cfg_q.ranged_mode <= 1'b0;
      cfg_q.range_limit <= 16'd16;
      cfg_q.page_limit  <= 32'd256;
      cfg_q.dir_base    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tib_front u_front (
    .kind_i         (kind_i),
    .range_start_i  (range_start_i),
    .range_length_i (range_length_i),
    .size_mask_i    (size_mask_i),
    .barrier_i      (barrier_i),
    .item_o         (fr_item),
    .keep_o         (fr_keep)
  );

  // dropped transactions are still accepted, they just never enter the queue
  assign in_ready_o = q_ready;
  assign q_push     = in_valid_i && q_ready && fr_keep;

  tib_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (fr_item),
    .ready_o (q_ready),
    .pop_i   (bk_st.pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  tib_back #(
    .MaxEntries (MaxEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_cmd_o   (out_cmd),
    .status_o    (bk_st)
  );

  assign command_o         = out_cmd.command;
  assign base_address_o    = out_cmd.base_address;
  assign depth_size_log2_o = out_cmd.depth_log2;
  assign out_start_o       = out_cmd.start;
  assign out_length_o      = out_cmd.length;
  assign step_size_log2_o  = out_cmd.step_log2;
  assign out_barrier_o     = out_cmd.barrier;
  assign last_o            = out_cmd.last;

  `ASSERT_NEVER(a_no_pop_in_flush, bk_st.flushing && bk_st.pop, "queue popped during flush")

  `ASSERT_IMPLIES(a_flush_ends_last, $fell(bk_st.flushing), out_valid_o && last_o, "flush ended without last command")

  `ASSERT_IMPLIES(a_inv_all_last, out_valid_o && (command_o == tib_pkg::CMD_ALL), last_o, "invalidate-all not marked last")

endmodule

`default_nettype wire

### hw/rtl/tib_front.sv
// ----------------------------------------------------------------------------
// tib_front
// Classifies input transactions, finds the page size range of an add and
// drops transactions that have no effect.
// ----------------------------------------------------------------------------
`default_nettype none

module tib_front (
  input  wire logic [1:0]              kind_i,
  input  wire logic [tib_pkg::AddrW-1:0] range_start_i,
  input  wire logic [tib_pkg::AddrW-1:0] range_length_i,
  input  wire logic [tib_pkg::AddrW-1:0] size_mask_i,
  input  wire logic [1:0]              barrier_i,
  output tib_pkg::tib_item_t           item_o,
  output logic                         keep_o
);

  logic [tib_pkg::Log2W-1:0] lo;
  logic [tib_pkg::Log2W-1:0] hi;
  tib_pkg::tib_op_e          op;

  // lowest set bit wins for lo, highest for hi
  always_comb begin
    lo = '0;
    for (int b = tib_pkg::AddrW - 1; b >= 0; b--) begin
      if (size_mask_i[b]) lo = tib_pkg::Log2W'(b);
    end
  end

  always_comb begin
    hi = '0;
    for (int b = 0; b < tib_pkg::AddrW; b++) begin
      if (size_mask_i[b]) hi = tib_pkg::Log2W'(b);
    end
  end

  always_comb begin
    op     = tib_pkg::OP_BEGIN;
    keep_o = 1'b0;
    case (kind_i)
      tib_pkg::KIND_BEGIN: begin
        op     = tib_pkg::OP_BEGIN;
        keep_o = 1'b1;
      end
      tib_pkg::KIND_ADD: begin
        op     = tib_pkg::OP_ADD;
        keep_o = |size_mask_i;
      end
      tib_pkg::KIND_END: begin
        op     = tib_pkg::OP_END;
        keep_o = 1'b1;
      end
      default: begin
        op     = tib_pkg::OP_BEGIN;
        keep_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    item_o.op      = op;
    item_o.start   = range_start_i;
    item_o.length  = range_length_i;
    item_o.lo      = lo;
    item_o.hi      = hi;
    item_o.barrier = (barrier_i > tib_pkg::BAR_SYSTEM) ? tib_pkg::BAR_SYSTEM : barrier_i;
  end

endmodule

`default_nettype wire

### hw/rtl/tib_queue.sv
// ----------------------------------------------------------------------------
// tib_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tib_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  tib_pkg::tib_item_t      item_i,
  output logic                    ready_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output tib_pkg::tib_item_t      item_o
);

  tib_pkg::tib_item_t slot_q [2];
  logic               wptr_q, wptr_d;
  logic               rptr_q, rptr_d;
  logic [1:0]         level_q, level_d;
  logic               do_push;
  logic               do_pop;

  assign ready_o = (level_q != 2'd2);
  assign valid_o = (level_q != 2'd0);
  assign item_o  = slot_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = do_push ? ~wptr_q : wptr_q;
    rptr_d  = do_pop ? ~rptr_q : rptr_q;
    level_d = level_q;
    if (do_push && !do_pop) level_d = level_q + 2'd1;
    else if (!do_push && do_pop) level_d = level_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      level_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= item_i;
  end

endmodule

`default_nettype wire

### hw/rtl/tib_back.sv
// ----------------------------------------------------------------------------
// tib_back
// Applies batch transactions, holds the entry store and sequences the
// invalidate commands of a flush into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tib_back #(
  parameter int unsigned MaxEntries = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  tib_pkg::tib_cfg_t  cfg_i,
  input  wire logic          q_valid_i,
  input  tib_pkg::tib_item_t q_item_i,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output tib_pkg::tib_cmd_t  out_cmd_o,
  output tib_pkg::tib_status_t status_o
);

  localparam int unsigned CntW = $clog2(MaxEntries + 2);
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_e;

  state_e                    state_q, state_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [16:0]               range_total_q, range_total_d;
  logic [63:0]               page_total_q, page_total_d;
  logic [tib_pkg::Log2W-1:0] largest_q, largest_d;
  logic [1:0]                batch_bar_q, batch_bar_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  tib_pkg::tib_cmd_t         out_q, out_d;
  logic                      load;

  tib_pkg::tib_entry_t       entry_mem_q [MaxEntries];
  tib_pkg::tib_entry_t       rd_q;
  tib_pkg::tib_entry_t       wr_entry;
  logic [IdxW-1:0]           rd_addr;
  logic                      wr_en;

  logic                      slot_free;
  logic                      pop;
  logic [1:0]                bar_new;
  logic                      limit_hit;
  logic                      inv_all;
  logic                      add_inv_all;
  logic [63:0]               pages;
  logic [64:0]               page_sum;
  logic                      flush_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop = (state_q == ST_IDLE) && q_valid_i &&
               ((q_item_i.op != tib_pkg::OP_END) || slot_free);
  assign bar_new = (q_item_i.barrier > batch_bar_q) ? q_item_i.barrier : batch_bar_q;
  assign limit_hit = cfg_i.ranged_mode ? (range_total_q > {1'b0, cfg_i.range_limit})
                                       : (page_total_q > {32'd0, cfg_i.page_limit});
  assign inv_all = !cfg_i.range_ok || (count_q > CntW'(MaxEntries)) || limit_hit;
  assign pages = q_item_i.length >> q_item_i.lo;
  assign page_sum = {1'b0, page_total_q} + {1'b0, pages};
  assign flush_last = ((CntW'(idx_q) + CntW'(1)) == count_q);

  // an add stores its entry only while the updated batch still qualifies
  assign add_inv_all = !cfg_i.range_ok || (count_d > CntW'(MaxEntries)) ||
                       (cfg_i.ranged_mode ? (range_total_d > {1'b0, cfg_i.range_limit})
                                          : (page_total_d > {32'd0, cfg_i.page_limit}));
  assign wr_en = pop && (q_item_i.op == tib_pkg::OP_ADD) && !add_inv_all;
  assign wr_entry = '{start: q_item_i.start, length: q_item_i.length,
                      lo: q_item_i.lo, hi: q_item_i.hi};

  // read one entry ahead: a command every cycle the output slot is free
  always_comb begin
    if (state_q == ST_FLUSH) begin
      rd_addr = slot_free ? IdxW'(idx_q + 1'b1) : idx_q;
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) entry_mem_q[count_q[IdxW-1:0]] <= wr_entry;
    rd_q <= entry_mem_q[rd_addr];
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    range_total_d = range_total_q;
    page_total_d  = page_total_q;
    largest_d     = largest_q;
    batch_bar_d   = batch_bar_q;
    idx_d         = idx_q;
    load          = 1'b0;
    out_d         = out_q;

    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (q_item_i.op)
            tib_pkg::OP_BEGIN: begin
              count_d       = '0;
              range_total_d = '0;
              page_total_d  = '0;
              largest_d     = '0;
              batch_bar_d   = '0;
            end
            tib_pkg::OP_ADD: begin
              batch_bar_d = bar_new;
              if (count_q <= CntW'(MaxEntries)) count_d = count_q + CntW'(1);
              if (cfg_i.ranged_mode) begin
                if (range_total_q != tib_pkg::RANGE_TOTAL_MAX) begin
                  range_total_d = range_total_q + 17'd1;
                end
              end else begin
                page_total_d = page_sum[64] ? '1 : page_sum[63:0];
              end
              if (q_item_i.hi > largest_q) largest_d = q_item_i.hi;
            end
            tib_pkg::OP_END: begin
              if (count_q != '0) begin
                batch_bar_d = bar_new;
                if (inv_all) begin
                  load               = 1'b1;
                  out_d.command      = tib_pkg::CMD_ALL;
                  out_d.base_address = cfg_i.dir_base;
                  out_d.depth_log2   = largest_q;
                  out_d.start        = '0;
                  out_d.length       = '0;
                  out_d.step_log2    = '0;
                  out_d.barrier      = bar_new;
                  out_d.last         = 1'b1;
                end else begin
                  state_d = ST_FLUSH;
                  idx_d   = '0;
                end
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          load               = 1'b1;
          out_d.command      = tib_pkg::CMD_RANGE;
          out_d.base_address = cfg_i.dir_base;
          out_d.depth_log2   = rd_q.hi;
          out_d.start        = rd_q.start;
          out_d.length       = rd_q.length;
          out_d.step_log2    = rd_q.lo;
          out_d.barrier      = flush_last ? batch_bar_q : 2'd0;
          out_d.last         = flush_last;
          idx_d              = IdxW'(idx_q + 1'b1);
          if (flush_last) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      range_total_q <= '0;
      page_total_q  <= '0;
      largest_q     <= '0;
      batch_bar_q   <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      range_total_q <= range_total_d;
      page_total_q  <= page_total_d;
      largest_q     <= largest_d;
      batch_bar_q   <= batch_bar_d;
      idx_q         <= idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_cmd_o         = out_q;
  assign status_o.flushing = (state_q == ST_FLUSH);
  assign status_o.pop      = pop;

endmodule

`default_nettype wire
